// ----- rtl/core/askf_pkg.sv -----
// Shared types and constants for the adaptive scalar Kalman filter.
package askf_pkg;

  localparam int VAL_W      = 32;
  localparam int GAIN_W     = 29;
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 29;
  localparam int CNT_W      = 5;

  localparam logic [GAIN_W-1:0] ONE_Q28 = GAIN_W'(1) << 28;

  // configuration register indexes
  localparam logic [1:0] CFG_PROCESS_NOISE    = 2'd0;
  localparam logic [1:0] CFG_NOISE_GAIN       = 2'd1;
  localparam logic [1:0] CFG_REINIT_VALUE     = 2'd2;
  localparam logic [1:0] CFG_INITIAL_VARIANCE = 2'd3;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } ds_ctrl_t;

endpackage

// ----- rtl/core/askf_divsqrt.sv -----
// Iterative shift-subtract unit: integer square root or fractional divide.
module askf_divsqrt (
  input  logic               clk,
  input  logic               rst,
  input  askf_pkg::ds_ctrl_t ctrl,
  input  logic [47:0]        opa,    // sqrt: radicand; div: dividend in [31:0]
  input  logic [44:0]        opb,    // div: divisor
  output logic               done,
  output logic [28:0]        result
);
  import askf_pkg::*;

  logic             busy;
  logic             first;
  op_t              op_reg;
  logic [CNT_W-1:0] cnt;
  logic [45:0]      rem;
  logic [28:0]      quo;
  logic [47:0]      shreg;
  logic [44:0]      den;

  logic [45:0] rem_sh;
  logic [45:0] trial;
  logic [46:0] diff;
  logic        ge;

  always_comb begin
    if (op_reg == OP_SQRT) begin
      rem_sh = {rem[43:0], shreg[47:46]};
      trial  = {20'b0, quo[23:0], 2'b01};
    end else begin
      // dividend never exceeds divisor, so the first step takes it unshifted
      rem_sh = first ? rem : {rem[44:0], 1'b0};
      trial  = {1'b0, den};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = !diff[46];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (ctrl.start) begin
        busy   <= 1'b1;
        op_reg <= ctrl.op;
        quo    <= '0;
        first  <= 1'b1;
        shreg  <= opa;
        den    <= opb;
        if (ctrl.op == OP_DIV) begin
          cnt <= CNT_W'(DIV_STEPS - 1);
          rem <= {14'b0, opa[31:0]};
        end else begin
          cnt <= CNT_W'(SQRT_STEPS - 1);
          rem <= '0;
        end
      end else if (busy) begin
        rem   <= ge ? diff[45:0] : rem_sh;
        quo   <= {quo[27:0], ge};
        shreg <= {shreg[45:0], 2'b00};
        first <= 1'b0;
        cnt   <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign result = quo;

endmodule

// ----- rtl/core/askf_mul.sv -----
// Registered signed-by-unsigned multiplier shared by the update sequence.
module askf_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] a,
  input  logic [28:0]        b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * $signed({1'b0, b});
    end
  end

endmodule

// ----- rtl/core/adaptive_scalar_kalman_filter.sv -----
// Top level: sequencer, state and configuration of the scalar Kalman filter.
//
// A sample runs from acceptance through the square root of the estimate and the
// gain divide to the output register; the divide is skipped when predicted
// variance and measurement noise are both zero. A new sample is accepted only
// once the last one has left the sequencer. The shared shift-subtract unit does
// a 24-step square root of the estimate followed by a 29-step gain divide, plus a
// single registered multiplier used three times (noise, estimate step, variance).
// The input is ready only while the sequencer is idle; a finished result waits
// in the output register, and the next sample can be accepted while it waits.
module adaptive_scalar_kalman_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] measurement, [32] reinit, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] estimate, [60:32] gain, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import askf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SQRT_GO   = 10'b00_0000_0010,
    S_SQRT_WAIT = 10'b00_0000_0100,
    S_RMUL      = 10'b00_0000_1000,
    S_DEN       = 10'b00_0001_0000,
    S_DIV_GO    = 10'b00_0010_0000,
    S_DIV_WAIT  = 10'b00_0100_0000,
    S_DMUL      = 10'b00_1000_0000,
    S_PMUL      = 10'b01_0000_0000,
    S_FIN       = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [27:0]       process_noise;
  logic [23:0]       noise_gain;
  logic [VAL_W-1:0]  reinit_value;
  logic [VAL_W-1:0]  initial_variance;

  logic              first_pending;
  logic [VAL_W-1:0]  state_estimate;
  logic [VAL_W-1:0]  state_variance;

  logic [VAL_W-1:0]  z_reg;
  logic [VAL_W-1:0]  x_reg;
  logic [VAL_W-1:0]  ppred;
  logic [44:0]       den_reg;
  logic [GAIN_W-1:0] k_reg;

  logic              out_valid;
  logic [63:0]       out_data;

  logic              in_fire;
  logic [VAL_W-1:0]  meas;
  logic [VAL_W-1:0]  x_sel;
  logic [VAL_W-1:0]  p_sel;
  logic [VAL_W:0]    p_sum;

  ds_ctrl_t          ds_ctrl;
  logic [47:0]       ds_opa;
  logic              ds_done;
  logic [28:0]       ds_result;

  logic              mul_en;
  logic signed [33:0] mul_a;
  logic [28:0]       mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] step;
  logic              out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign meas          = s_axis_tdata[31:0];
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    if (first_pending) begin
      x_sel = meas;
      p_sel = initial_variance;
    end else begin
      x_sel = s_axis_tdata[32] ? reinit_value : state_estimate;
      p_sel = state_variance;
    end
    p_sum = {1'b0, p_sel} + {5'b0, process_noise};
  end

  // shared square root / divide unit
  always_comb begin
    ds_ctrl.start = (state == S_SQRT_GO) || ((state == S_DIV_GO) && (den_reg != '0));
    ds_ctrl.op    = (state == S_SQRT_GO) ? OP_SQRT : OP_DIV;
    if (state == S_SQRT_GO) begin
      // negative or zero estimate gives zero noise
      ds_opa = (x_reg[31] || (x_reg == '0)) ? '0 : {x_reg, 16'b0};
    end else begin
      ds_opa = {16'b0, ppred};
    end
  end

  askf_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ds_ctrl),
    .opa    (ds_opa),
    .opb    (den_reg),
    .done   (ds_done),
    .result (ds_result)
  );

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_RMUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({10'b0, ds_result[23:0]});
        mul_b  = {5'b0, noise_gain};
      end
      S_DMUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({z_reg[31], z_reg[31], z_reg}) -
                 $signed({x_reg[31], x_reg[31], x_reg});
        mul_b  = k_reg;
      end
      S_PMUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b0, ppred});
        mul_b  = ONE_Q28 - k_reg;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  askf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign step = prod >>> 28;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_fire) state_next = S_SQRT_GO;
      S_SQRT_GO:   state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: if (ds_done) state_next = S_RMUL;
      S_RMUL:      state_next = S_DEN;
      S_DEN:       state_next = S_DIV_GO;
      S_DIV_GO:    state_next = (den_reg == '0) ? S_DMUL : S_DIV_WAIT;
      S_DIV_WAIT:  if (ds_done) state_next = S_DMUL;
      S_DMUL:      state_next = S_PMUL;
      S_PMUL:      state_next = S_FIN;
      S_FIN:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      first_pending    <= 1'b1;
      state_estimate   <= '0;
      state_variance   <= '0;
      out_valid        <= 1'b0;
      process_noise    <= 28'd26844;
      noise_gain       <= 24'd65536;
      reinit_value     <= 32'd84214;
      initial_variance <= 32'd536870912;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROCESS_NOISE:    process_noise    <= cfg_data[27:0];
          CFG_NOISE_GAIN:       noise_gain       <= cfg_data[23:0];
          CFG_REINIT_VALUE:     reinit_value     <= cfg_data;
          CFG_INITIAL_VARIANCE: initial_variance <= cfg_data;
          default: ;
        endcase
      end

      // a new result may replace the one taken in the same cycle
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            first_pending <= 1'b0;
            z_reg         <= meas;
            x_reg         <= x_sel;
            ppred         <= p_sum[VAL_W] ? '1 : p_sum[VAL_W-1:0];
          end
        end
        S_DEN: begin
          den_reg <= {13'b0, ppred} + {1'b0, prod[47:4]};
        end
        S_DIV_GO: begin
          if (den_reg == '0) k_reg <= '0;
        end
        S_DIV_WAIT: begin
          if (ds_done) k_reg <= ds_result;
        end
        S_PMUL: begin
          // estimate step lands between old estimate and measurement
          x_reg <= x_reg + step[31:0];
        end
        S_FIN: begin
          if (out_free) begin
            state_estimate <= x_reg;
            state_variance <= prod[59:28];
            out_data       <= {3'b0, k_reg, x_reg};
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef SYNTH
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_SQRT_GO)
    else $error("accepted sample did not start the square root");

  a_done_in_wait : assert property (@(posedge clk) disable iff (rst)
    ds_done |-> (state == S_SQRT_WAIT) || (state == S_DIV_WAIT))
    else $error("shared unit finished outside a wait state");

  a_gain_limit : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[60:32] <= ONE_Q28)
    else $error("gain above one");

  a_out_from_fin : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_FIN)
    else $error("result loaded outside the final step");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the adaptive scalar Kalman filter.
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT    = 4000;
  localparam int ITEMS_PER_SET  = 117;
  localparam logic [63:0] GAIN_ONE = 64'd1 << 28;

  typedef struct {
    logic [31:0] meas;
    logic        reinit;
  } sample_t;

  typedef struct {
    logic [31:0] estimate;
    logic [28:0] gain;
  } filter_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [31:0] measurement, [32] reinit
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [31:0] estimate, [60:32] gain
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sample_t     sample_queue[$];
  filter_out_t predicted_outputs[$];
  sample_t     next_sample;
  filter_out_t wanted;

  int sender_idle_pct   = 31;
  int receiver_idle_pct = 46;
  int err_count         = 0;
  int stall_cycles      = 0;
  logic [31:0] sensor_level = 32'h0019_0000;

  // filter model: configuration copy and state
  logic [27:0] q_noise    = 28'd26844;
  logic [23:0] gamma_gain = 24'd65536;
  logic [31:0] reinit_est = 32'd84214;
  logic [31:0] init_var   = 32'd536870912;
  logic        seed_pending = 1'b1;
  logic [31:0] est_now = '0;
  logic [31:0] var_now = '0;

  adaptive_scalar_kalman_filter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // advance the filter model by one sample and queue the expected output
  function automatic void filter_model_step(input logic [31:0] meas, input logic reinit);
    logic signed [63:0] z;
    logic signed [63:0] x;
    logic signed [63:0] prod;
    logic [63:0] p;
    logic [63:0] ppred;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] den;
    logic [63:0] k;
    filter_out_t res;
    z = {{32{meas[31]}}, meas};
    if (seed_pending) begin
      x = z;
      p = {32'd0, init_var};
      seed_pending = 1'b0;
    end else begin
      x = reinit ? {{32{reinit_est[31]}}, reinit_est} : {{32{est_now[31]}}, est_now};
      p = {32'd0, var_now};
    end
    ppred = p + {36'd0, q_noise};
    if (ppred > 64'hFFFF_FFFF) ppred = 64'hFFFF_FFFF;
    s = (x > 0) ? floor_sqrt(64'(x) << 16) : 64'd0;
    r = ({40'd0, gamma_gain} * s) >> 4;
    den = ppred + r;
    k = (den == 0) ? 64'd0 : (ppred << 28) / den;
    if (k > GAIN_ONE) k = GAIN_ONE;
    prod = $signed(k) * (z - x);
    x = x + (prod >>> 28);
    if (x > 64'sh7FFF_FFFF) x = 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) x = -64'sh8000_0000;
    p = (ppred * (GAIN_ONE - k)) >> 28;
    est_now = x[31:0];
    var_now = p[31:0];
    res.estimate = x[31:0];
    res.gain = k[28:0];
    predicted_outputs.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("mismatch at %0t: %s got %h exp %h", $realtime, what, got, exp_val);
    err_count++;
  endtask

  task automatic push_sample(input logic [31:0] meas, input logic reinit);
    sample_t it;
    it.meas = meas;
    it.reinit = reinit;
    sample_queue.push_back(it);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      askf_pkg::CFG_PROCESS_NOISE:    q_noise    = val[27:0];
      askf_pkg::CFG_NOISE_GAIN:       gamma_gain = val[23:0];
      askf_pkg::CFG_REINIT_VALUE:     reinit_est = val;
      askf_pkg::CFG_INITIAL_VARIANCE: init_var   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic program_filter(input logic [31:0] q, input logic [31:0] g,
                                input logic [31:0] ri, input logic [31:0] iv);
    write_cfg(askf_pkg::CFG_PROCESS_NOISE, q);
    write_cfg(askf_pkg::CFG_NOISE_GAIN, g);
    write_cfg(askf_pkg::CFG_REINIT_VALUE, ri);
    write_cfg(askf_pkg::CFG_INITIAL_VARIANCE, iv);
  endtask

  // sender holds off until every queued sample is in and every result is out
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0);
  endtask

  function automatic logic [31:0] random_cfg_value(input logic [31:0] mask);
    case ($urandom_range(5))
      0: return 32'd0;
      1: return mask;
      2, 3: return $urandom & mask;
      default: return ($urandom & mask) >> $urandom_range(4, 20);
    endcase
  endfunction

  // mostly a slowly drifting sensor reading, with some noise and extremes
  function automatic logic [31:0] random_measurement();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom;
      default: begin
        sensor_level = sensor_level + 32'($signed($urandom_range(0, 8191)) - 4096);
        return sensor_level + 32'($signed($urandom_range(0, 65535)) - 32768);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        filter_model_step(s_axis_tdata[31:0], s_axis_tdata[32]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_sample = sample_queue.pop_front();
          s_axis_tdata  <= {7'd0, next_sample.reinit, next_sample.meas};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 64'd0);
        end else begin
          wanted = predicted_outputs.pop_front();
          if (m_axis_tdata[31:0] !== wanted.estimate)
            report_mismatch("estimate", 64'(m_axis_tdata[31:0]), 64'(wanted.estimate));
          if (m_axis_tdata[60:32] !== wanted.gain)
            report_mismatch("gain", 64'(m_axis_tdata[60:32]), 64'(wanted.gain));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("FAIL adaptive_scalar_kalman_filter");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset configuration; first sample carries reinit, which must be ignored
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h1234_5678, 1'b1);
    push_sample(32'h0001_0000, 1'b0);
    push_sample(32'hFFFF_0000, 1'b0);
    wait_drained();

    // no process noise, no measurement noise: gain one, then zero denominator
    program_filter(32'd0, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF);
    push_sample(32'h0005_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'h0000_0000, 1'b0);
    wait_drained();

    // maximum noise settings, negative estimates clamp the square root at zero
    program_filter(32'h0FFF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF, 32'd0);
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h4000_0000, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b0);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin sender_idle_pct = 31; receiver_idle_pct = 46; end
        1: begin sender_idle_pct = 46; receiver_idle_pct = 31; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      for (int set = 0; set < 4; set++) begin
        program_filter(random_cfg_value(32'h0FFF_FFFF), random_cfg_value(32'h00FF_FFFF),
                       random_cfg_value(32'hFFFF_FFFF), random_cfg_value(32'hFFFF_FFFF));
        for (int n = 0; n < ITEMS_PER_SET; n++)
          push_sample(random_measurement(), ($urandom_range(15) == 0));
        wait_drained();
      end
    end

    repeat (100) @(posedge clk);
    if (predicted_outputs.size() != 0)
      report_mismatch("results never arrived", 64'(predicted_outputs.size()), 64'd0);
    if (err_count == 0) begin
      $display("PASS adaptive_scalar_kalman_filter");
    end else begin
      $display("FAIL adaptive_scalar_kalman_filter");
    end
    $finish;
  end

endmodule

// ----- adaptive_scalar_kalman_filter.f -----
rtl/core/askf_pkg.sv
rtl/core/askf_divsqrt.sv
rtl/core/askf_mul.sv
rtl/core/adaptive_scalar_kalman_filter.sv
tb/testbench.sv
